FILE: src/iate_pkg.sv
// ----------------------------------------------------------------------------
// iate_pkg
// Shared types and constants of the integer array table engine: opcodes,
// result status codes and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package iate_pkg;

	localparam int MAX_RESULTS = 64;
	localparam int IDX_W       = 6;
	localparam int VAL_W       = 32;

	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_APPEND = 3'd1,
		OP_DELETE = 3'd2,
		OP_MAX    = 3'd3,
		OP_SORT   = 3'd4,
		OP_SEARCH = 3'd5,
		OP_PRIMES = 3'd6,
		OP_DUMP   = 3'd7
	} op_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_BADPOS   = 3'd2;
	localparam logic [2:0] ST_NONE     = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	typedef enum logic [1:0] {
		RD_IDX,
		RD_IDX1,
		RD_JDX
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_APP,
		WR_DEL,
		WR_SORT_I,
		WR_SORT_J
	} wr_sel_t;

	typedef enum logic [1:0] {
		EM_NONE,
		EM_CODE,
		EM_MAX,
		EM_FLUSH
	} emit_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    clr_cnt;
		logic    inc_cnt;
		logic    dec_cnt;
		logic    idx_ld_pos;
		logic    idx_inc;
		logic    jdx_ld;
		logic    jdx_inc;
		logic    rd_en;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		logic    held_ld;
		logic    max_step;
		logic    push_rd;
		logic    push_held;
		logic    prime_start;
		emit_t   emit;
		logic [2:0] code;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic cnt_zero;
		logic full;
		logic pos_bad;
		logic idx_last;
		logic scan_end;
		logic jdx_end;
		logic match;
		logic rd_lt_held;
		logic prime_done;
		logic prime_yes;
	} sts_t;

endpackage

FILE: src/iate_ram.sv
// ----------------------------------------------------------------------------
// iate_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module iate_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/iate_prime.sv
// ----------------------------------------------------------------------------
// iate_prime
// Trial division primality test: divisors from two while d*d <= v, each
// remainder from a restoring divider that retires one bit per cycle.
// ----------------------------------------------------------------------------
module iate_prime (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] value,
	output logic        done,
	output logic        is_prime
);

	typedef enum logic [1:0] {
		P_IDLE,
		P_TEST,
		P_DIV
	} pstate_t;

	pstate_t     state_q;
	logic        done_q;
	logic        yes_q;
	logic [30:0] v_q;
	logic [15:0] d_q;
	logic [31:0] sq_q;
	logic [15:0] rem_q;
	logic [4:0]  bit_q;
	logic [16:0] rem_sh;
	logic [16:0] rem_nx;

	// one restoring division step
	always_comb begin
		rem_sh = {rem_q, v_q[bit_q]};
		rem_nx = (rem_sh >= {1'b0, d_q}) ? (rem_sh - {1'b0, d_q}) : rem_sh;
	end

	// sequencer and divisor registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			done_q  <= 1'b0;
			yes_q   <= 1'b0;
			v_q     <= '0;
			d_q     <= '0;
			sq_q    <= '0;
			rem_q   <= '0;
			bit_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				P_IDLE: begin
					if (start) begin
						if (value[31] || (value < 32'd2)) begin
							done_q <= 1'b1;
							yes_q  <= 1'b0;
						end else begin
							v_q     <= value[30:0];
							d_q     <= 16'd2;
							sq_q    <= 32'd4;
							state_q <= P_TEST;
						end
					end
				end
				P_TEST: begin
					if (sq_q > {1'b0, v_q}) begin
						done_q  <= 1'b1;
						yes_q   <= 1'b1;
						state_q <= P_IDLE;
					end else begin
						rem_q   <= '0;
						bit_q   <= 5'd30;
						state_q <= P_DIV;
					end
				end
				P_DIV: begin
					rem_q <= rem_nx[15:0];
					if (bit_q == 5'd0) begin
						if (rem_nx == 17'd0) begin
							done_q  <= 1'b1;
							yes_q   <= 1'b0;
							state_q <= P_IDLE;
						end else begin
							// (d+1)^2 = d^2 + 2d + 1
							sq_q    <= sq_q + 32'({d_q, 1'b1});
							d_q     <= d_q + 16'd1;
							state_q <= P_TEST;
						end
					end else begin
						bit_q <= bit_q - 5'd1;
					end
				end
				default: begin
					state_q <= P_IDLE;
				end
			endcase
		end
	end

	assign done     = done_q;
	assign is_prime = yes_q;

endmodule

FILE: src/iate_dp.sv
// ----------------------------------------------------------------------------
// iate_dp
// Datapath: list storage, count, scan indexes, running maximum, held entry
// for sort and prime test, one pending result and the result registers.
// ----------------------------------------------------------------------------
module iate_dp #(
	parameter int DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [2:0]            opcode,
	input  logic signed [31:0]    operand_value,
	input  logic [5:0]            position,
	input  iate_pkg::cmd_t        cmd,
	output iate_pkg::sts_t        sts,
	output logic                  strobe,
	output logic signed [31:0]    result_value,
	output logic [5:0]            result_index,
	output logic [2:0]            status,
	output logic                  last
);

	import iate_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > IDX_W) ? CW : IDX_W;
	localparam int KW = $clog2(MAX_RESULTS);

	op_t         op_q;
	logic [31:0] val_q;
	logic [5:0]  pos_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] jdx_q;
	logic [CW:0]   idx_p1;
	logic [31:0] held_q;
	logic [31:0] best_q;
	logic [5:0]  bidx_q;
	logic        pend_v_q;
	logic [31:0] pend_val_q;
	logic [5:0]  pend_idx_q;
	logic [KW-1:0] k_q;
	logic        strobe_q;
	logic [31:0] rval_q;
	logic [5:0]  ridx_q;
	logic [2:0]  rst_q;
	logic        last_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic [AW-1:0] raddr;
	logic [31:0]   rdata;
	logic [XW-1:0] idx_x;
	logic [5:0]    idx6;
	logic          push;
	logic [31:0]   push_val;
	logic          prime_done;
	logic          prime_yes;

	assign idx_p1 = {1'b0, idx_q} + {{CW{1'b0}}, 1'b1};
	assign idx_x  = XW'(idx_q);
	assign idx6   = idx_x[IDX_W-1:0];

	// read address select
	always_comb begin
		case (cmd.rd_sel)
			RD_IDX1: raddr = idx_p1[AW-1:0];
			RD_JDX:  raddr = jdx_q[AW-1:0];
			default: raddr = idx_q[AW-1:0];
		endcase
	end

	// write port select
	always_comb begin
		we    = 1'b1;
		waddr = idx_q[AW-1:0];
		wdata = held_q;
		case (cmd.wr_sel)
			WR_APP: begin
				waddr = cnt_q[AW-1:0];
				wdata = val_q;
			end
			WR_DEL: begin
				wdata = rdata;
			end
			WR_SORT_I: begin
				wdata = held_q;
			end
			WR_SORT_J: begin
				waddr = jdx_q[AW-1:0];
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	iate_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	iate_prime u_prime (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.prime_start),
		.value   (rdata),
		.done    (prime_done),
		.is_prime(prime_yes)
	);

	assign push     = cmd.push_rd || cmd.push_held;
	assign push_val = cmd.push_held ? held_q : rdata;

	// status toward the controller
	always_comb begin
		sts.op         = op_q;
		sts.cnt_zero   = (cnt_q == '0);
		sts.full       = (cnt_q == CW'(DEPTH));
		sts.pos_bad    = (XW'(pos_q) >= XW'(cnt_q));
		sts.idx_last   = (idx_p1 >= {1'b0, cnt_q});
		sts.scan_end   = (idx_q == cnt_q) || (pend_v_q && (k_q == KW'(MAX_RESULTS - 1)));
		sts.jdx_end    = (jdx_q == cnt_q);
		sts.match      = (rdata == val_q);
		sts.rd_lt_held = ($signed(rdata) < $signed(held_q));
		sts.prime_done = prime_done;
		sts.prime_yes  = prime_yes;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
			k_q      <= '0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			if (cmd.clr_cnt) begin
				cnt_q <= '0;
			end else if (cmd.inc_cnt) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.dec_cnt) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.load) begin
				pend_v_q <= 1'b0;
				k_q      <= '0;
			end else if (push) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					k_q      <= k_q + KW'(1);
					strobe_q <= 1'b1;
				end
			end
			if (cmd.emit != EM_NONE) begin
				strobe_q <= 1'b1;
				last_q   <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(opcode);
			val_q <= operand_value;
			pos_q <= position;
			idx_q <= '0;
		end else if (cmd.idx_ld_pos) begin
			idx_q <= CW'(pos_q);
		end else if (cmd.idx_inc) begin
			idx_q <= idx_p1[CW-1:0];
		end
		if (cmd.jdx_ld) begin
			jdx_q <= idx_p1[CW-1:0];
		end else if (cmd.jdx_inc) begin
			jdx_q <= jdx_q + CW'(1);
		end
		if (cmd.held_ld || (cmd.wr_sel == WR_SORT_J)) begin
			held_q <= rdata;
		end
		// running maximum, first occurrence wins
		if (cmd.max_step && ((idx_q == '0) || ($signed(best_q) < $signed(rdata)))) begin
			best_q <= rdata;
			bidx_q <= idx6;
		end
		// one result is held back so the final one can carry last
		if (push) begin
			pend_val_q <= push_val;
			pend_idx_q <= idx6;
			rval_q     <= pend_val_q;
			ridx_q     <= pend_idx_q;
			rst_q      <= ST_OK;
		end
		case (cmd.emit)
			EM_CODE: begin
				rval_q <= '0;
				ridx_q <= '0;
				rst_q  <= cmd.code;
			end
			EM_MAX: begin
				rval_q <= best_q;
				ridx_q <= bidx_q;
				rst_q  <= ST_OK;
			end
			EM_FLUSH: begin
				rval_q <= pend_v_q ? pend_val_q : '0;
				ridx_q <= pend_v_q ? pend_idx_q : '0;
				rst_q  <= pend_v_q ? ST_OK : cmd.code;
			end
			default: begin
			end
		endcase
	end

	assign strobe       = strobe_q;
	assign result_value = rval_q;
	assign result_index = ridx_q;
	assign status       = rst_q;
	assign last         = last_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("element count above depth");
	a_push_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(push && pend_v_q && !cmd.load) |=> (strobe_q && !last_q))
		else $error("displaced pending result not sent");
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && last_q) |=> !strobe_q)
		else $error("beat right after the final beat");
	a_mid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && !last_q) |-> (rst_q == ST_OK))
		else $error("error status on a non-final beat");
`endif

endmodule

FILE: src/iate_ctrl.sv
// ----------------------------------------------------------------------------
// iate_ctrl
// Controller: decodes the request and steps the datapath through the scan,
// delete, exchange sort and prime test sequences.
// ----------------------------------------------------------------------------
module iate_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  iate_pkg::sts_t sts,
	output iate_pkg::cmd_t cmd,
	output logic           busy
);

	import iate_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_SCAN_RD,
		S_SCAN_EV,
		S_PRIME,
		S_DEL_RD,
		S_DEL_WR,
		S_SORT_I,
		S_SORT_IH,
		S_SORT_J,
		S_SORT_JE
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.op)
					OP_CLEAR: begin
						cmd.clr_cnt = 1'b1;
						cmd.emit    = EM_CODE;
						cmd.code    = ST_OK;
						state_d     = S_IDLE;
					end
					OP_APPEND: begin
						cmd.emit = EM_CODE;
						state_d  = S_IDLE;
						if (sts.full) begin
							cmd.code = ST_FULL;
						end else begin
							cmd.code    = ST_OK;
							cmd.wr_sel  = WR_APP;
							cmd.inc_cnt = 1'b1;
						end
					end
					OP_DELETE: begin
						if (sts.pos_bad) begin
							cmd.emit = EM_CODE;
							cmd.code = ST_BADPOS;
							state_d  = S_IDLE;
						end else begin
							cmd.idx_ld_pos = 1'b1;
							state_d        = S_DEL_RD;
						end
					end
					OP_MAX: begin
						if (sts.cnt_zero) begin
							cmd.emit = EM_CODE;
							cmd.code = ST_NONE;
							state_d  = S_IDLE;
						end else begin
							state_d = S_SCAN_RD;
						end
					end
					OP_SORT: begin
						state_d = S_SORT_I;
					end
					default: begin
						state_d = S_SCAN_RD;
					end
				endcase
			end
			S_SCAN_RD: begin
				if (sts.scan_end) begin
					cmd.emit = (sts.op == OP_MAX) ? EM_MAX : EM_FLUSH;
					cmd.code = (sts.op == OP_SEARCH) ? ST_NOTFOUND : ST_NONE;
					state_d  = S_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX;
					state_d    = S_SCAN_EV;
				end
			end
			S_SCAN_EV: begin
				case (sts.op)
					OP_MAX: begin
						cmd.max_step = 1'b1;
						cmd.idx_inc  = 1'b1;
						state_d      = S_SCAN_RD;
					end
					OP_SEARCH: begin
						cmd.push_rd = sts.match;
						cmd.idx_inc = 1'b1;
						state_d     = S_SCAN_RD;
					end
					OP_PRIMES: begin
						cmd.held_ld     = 1'b1;
						cmd.prime_start = 1'b1;
						state_d         = S_PRIME;
					end
					default: begin
						cmd.push_rd = 1'b1;
						cmd.idx_inc = 1'b1;
						state_d     = S_SCAN_RD;
					end
				endcase
			end
			S_PRIME: begin
				if (sts.prime_done) begin
					cmd.push_held = sts.prime_yes;
					cmd.idx_inc   = 1'b1;
					state_d       = S_SCAN_RD;
				end
			end
			S_DEL_RD: begin
				if (sts.idx_last) begin
					cmd.dec_cnt = 1'b1;
					cmd.emit    = EM_CODE;
					cmd.code    = ST_OK;
					state_d     = S_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX1;
					state_d    = S_DEL_WR;
				end
			end
			S_DEL_WR: begin
				cmd.wr_sel  = WR_DEL;
				cmd.idx_inc = 1'b1;
				state_d     = S_DEL_RD;
			end
			S_SORT_I: begin
				if (sts.idx_last) begin
					cmd.emit = EM_CODE;
					cmd.code = ST_OK;
					state_d  = S_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX;
					state_d    = S_SORT_IH;
				end
			end
			S_SORT_IH: begin
				cmd.held_ld = 1'b1;
				cmd.jdx_ld  = 1'b1;
				state_d     = S_SORT_J;
			end
			S_SORT_J: begin
				if (sts.jdx_end) begin
					cmd.wr_sel  = WR_SORT_I;
					cmd.idx_inc = 1'b1;
					state_d     = S_SORT_I;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_JDX;
					state_d    = S_SORT_JE;
				end
			end
			S_SORT_JE: begin
				// smaller entry moves into the held slot, held one goes to j
				if (sts.rd_lt_held) begin
					cmd.wr_sel = WR_SORT_J;
				end
				cmd.jdx_inc = 1'b1;
				state_d     = S_SORT_J;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

`ifndef SYNTHESIS
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (state_q == S_IDLE))
		else $error("request taken while busy");
	a_disp_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_DISP))
		else $error("request not decoded after acceptance");
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit != EM_NONE) |=> !busy)
		else $error("still busy after the final beat");
`endif

endmodule

FILE: src/int_array_table_engine.sv
// ----------------------------------------------------------------------------
// int_array_table_engine
// Bounded list of signed 32-bit values with clear, append, delete, max,
// exchange sort, search, prime filter and dump requests.
// ----------------------------------------------------------------------------
// Usage:
//   A request (opcode, operand_value, position) is taken on a clock edge with
//   start high and busy low. busy stays high until the request's final
//   result beat has been issued. Each result beat is shown for one cycle
//   with strobe high; the final beat of a request has last high. The
//   receiver cannot hold beats off and none are buffered beyond that cycle.
//   Latency: clear, append and bad-position errors answer two cycles after
//   acceptance. Delete takes about 2*(count-position) cycles, max, search
//   and dump about 2*count, sort about count*count cycles; all are set by
//   the single read port of the list memory. The prime filter adds a trial
//   division per entry, up to about 32*sqrt(value) cycles, set by the
//   bit-serial remainder unit. At most 64 beats per request.
//   Reset empties the list; no clearing pass is run, so the engine takes a
//   request in the first cycle after reset.
// ----------------------------------------------------------------------------
module int_array_table_engine #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         opcode,
	input  logic signed [31:0] operand_value,
	input  logic [5:0]         position,
	output logic               strobe,
	output logic signed [31:0] result_value,
	output logic [5:0]         result_index,
	output logic [2:0]         status,
	output logic               last
);

	import iate_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic busy_w;

	// sequencing
	iate_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy_w)
	);

	// storage and result path
	iate_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.opcode       (opcode),
		.operand_value(operand_value),
		.position     (position),
		.cmd          (cmd),
		.sts          (sts),
		.strobe       (strobe),
		.result_value (result_value),
		.result_index (result_index),
		.status       (status),
		.last         (last)
	);

	assign busy = busy_w;

endmodule
